>>> rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared codes for the buddy page allocator: status, tag kinds, field widths.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam int ORDER_W = 5;
	localparam int TAG_W   = 7;
	localparam int SIZE_W  = 32;
	localparam int ADDR_W  = 22;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

	localparam logic [1:0] KIND_INTERIOR = 2'd0;
	localparam logic [1:0] KIND_FREE     = 2'd1;
	localparam logic [1:0] KIND_ALLOC    = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

endpackage

>>> rtl/bpa_ram.sv
// ---------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bpa_ram #(
	parameter int DEPTH = 960,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator over four fixed root blocks with per-order free lists.
// ---------------------------------------------------------------------------
// Input channel (s_axis): tuser is the operation (0 allocate, 1 free), tdata
// carries the byte size and the byte address to free. One request at a time:
// tready is high only while the sequencer sits idle.
// Output channel (m_axis): one result per request, status and block address,
// held in an output register until taken. A stalled receiver keeps the result
// in place; the next request is still accepted, and the sequencer waits at its
// end until the output register frees up.
// Steps per request (tags and link fields live in RAMs that share one read
// address; the free-list heads are registers):
//   allocate: take it, size to order, scan the free lists upward, unlink the
//             head, split down pushing each buddy, tag the block, hand off.
//   free:     take it, check the tag and push, merge with a free buddy while
//             one is found, stop merging, hand off.
// After reset the tag and link RAMs are swept, one page per cycle, over all
// NUM_PAGES pages (960 at the defaults); no request is taken before that.
// ---------------------------------------------------------------------------
module buddy_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_ORDER  = 10,
	parameter int PAGE_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // size_bytes[31:0], free_address[63:32]
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[1:0], block_address[23:2]
);

	localparam int PW        = MAX_ORDER;
	localparam int NUM_PAGES = 15 << (MAX_ORDER - 4);
	localparam int HW        = $clog2(MAX_ORDER + 1);
	localparam int PGS_W     = 33 - PAGE_SHIFT;
	localparam int CW        = (PGS_W > MAX_ORDER + 2) ? PGS_W : MAX_ORDER + 2;
	localparam int XW        = PW + PAGE_SHIFT + ADDR_W;
	localparam int FW        = 32 - PAGE_SHIFT;

	localparam logic [PW-1:0] NIL   = PW'(NUM_PAGES);
	localparam logic [PW-1:0] ROOT0 = PW'(0);
	localparam logic [PW-1:0] ROOT1 = PW'(8 << (MAX_ORDER - 4));
	localparam logic [PW-1:0] ROOT2 = PW'(12 << (MAX_ORDER - 4));
	localparam logic [PW-1:0] ROOT3 = PW'(14 << (MAX_ORDER - 4));
	localparam logic [ORDER_W-1:0] RORD0 = ORDER_W'(MAX_ORDER - 1);
	localparam logic [ORDER_W-1:0] RORD1 = ORDER_W'(MAX_ORDER - 2);
	localparam logic [ORDER_W-1:0] RORD2 = ORDER_W'(MAX_ORDER - 3);
	localparam logic [ORDER_W-1:0] RORD3 = ORDER_W'(MAX_ORDER - 4);
	localparam logic [ORDER_W-1:0] OMAX  = ORDER_W'(MAX_ORDER);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SIZE, S_SEARCH, S_SPLIT, S_UR, S_UW, S_PA, S_PB,
		S_FRD, S_FTAG, S_MCHK, S_MTAG, S_MUL2, S_MHI, S_DONE
	} state_t;

	state_t state_q, ret_q;

	logic [PW-1:0]      clr_q, pg_q, bud_q, ul_pg_q, push_pg_q, h_q;
	logic [TAG_W-1:0]   push_tag_q;
	logic [ORDER_W-1:0] o_q, want_q;
	logic [PGS_W-1:0]   pages_q;
	logic [PW-1:0]      heads_q [MAX_ORDER+1];
	logic [STAT_W-1:0]  res_status_q, out_status_q;
	logic [ADDR_W-1:0]  res_addr_q, out_addr_q;
	logic               out_valid_q;

	// ram ports
	logic               tag_we, nxt_we, prv_we;
	logic [PW-1:0]      tag_wa, nxt_wa, prv_wa, rd_addr;
	logic [TAG_W-1:0]   tag_wd, tag_rd;
	logic [PW-1:0]      nxt_wd, prv_wd, nxt_rd, prv_rd;

	logic [PW-1:0]      head_o, bud_c, one_o, lo_c, hi_c;
	logic [PW-1:0]      split_bud;
	logic [ORDER_W-1:0] o_dec;
	logic               root_c;
	logic [TAG_W-1:0]   clr_tag;
	logic [FW-1:0]      fpg;
	logic [XW-1:0]      addr_x;

	assign head_o    = heads_q[o_q[HW-1:0]];
	assign one_o     = PW'(1) << o_q;
	assign bud_c     = pg_q ^ one_o;
	assign o_dec     = o_q - ORDER_W'(1);
	assign split_bud = pg_q ^ (PW'(1) << o_dec);
	assign lo_c      = (pg_q < bud_q) ? pg_q : bud_q;
	assign hi_c      = (pg_q < bud_q) ? bud_q : pg_q;
	assign root_c    = (pg_q == ROOT0 && o_q == RORD0) || (pg_q == ROOT1 && o_q == RORD1) ||
	                   (pg_q == ROOT2 && o_q == RORD2) || (pg_q == ROOT3 && o_q == RORD3);
	assign fpg       = s_axis_tdata[63:32+PAGE_SHIFT];
	assign addr_x    = XW'(pg_q) << PAGE_SHIFT;

	always_comb begin
		clr_tag = {KIND_INTERIOR, ORDER_W'(0)};
		if (clr_q == ROOT0)      clr_tag = {KIND_FREE, RORD0};
		else if (clr_q == ROOT1) clr_tag = {KIND_FREE, RORD1};
		else if (clr_q == ROOT2) clr_tag = {KIND_FREE, RORD2};
		else if (clr_q == ROOT3) clr_tag = {KIND_FREE, RORD3};
	end

	bpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(TAG_W)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(rd_addr), .rdata(tag_rd)
	);
	bpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(PW)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(rd_addr), .rdata(nxt_rd)
	);
	bpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(PW)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(rd_addr), .rdata(prv_rd)
	);

	// memory port steering per sequencer step
	always_comb begin
		tag_we = 1'b0; tag_wa = pg_q;    tag_wd = push_tag_q;
		nxt_we = 1'b0; nxt_wa = push_pg_q; nxt_wd = head_o;
		prv_we = 1'b0; prv_wa = push_pg_q; prv_wd = NIL;
		rd_addr = pg_q;
		unique case (state_q)
			S_CLR: begin
				tag_we = 1'b1; tag_wa = clr_q; tag_wd = clr_tag;
				nxt_we = 1'b1; nxt_wa = clr_q; nxt_wd = NIL;
				prv_we = 1'b1; prv_wa = clr_q; prv_wd = NIL;
			end
			S_PA: begin
				tag_we = 1'b1; tag_wa = push_pg_q;
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			S_PB: begin
				prv_we = (h_q != NIL); prv_wa = h_q; prv_wd = push_pg_q;
			end
			S_UR: rd_addr = ul_pg_q;
			S_UW: begin
				if (head_o == ul_pg_q) begin
					prv_we = (nxt_rd != NIL); prv_wa = nxt_rd; prv_wd = NIL;
				end else begin
					nxt_we = (prv_rd != NIL); nxt_wa = prv_rd; nxt_wd = nxt_rd;
					prv_we = (nxt_rd != NIL); prv_wa = nxt_rd; prv_wd = prv_rd;
				end
			end
			S_SPLIT: begin
				tag_we = (o_q <= want_q); tag_wa = pg_q; tag_wd = {KIND_ALLOC, want_q};
			end
			S_MCHK: rd_addr = bud_c;
			S_MHI: begin
				tag_we = 1'b1; tag_wa = hi_c; tag_wd = {KIND_INTERIOR, ORDER_W'(0)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= S_IDLE;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= MAX_ORDER; k++) begin
				if (k == MAX_ORDER - 1)      heads_q[k] <= ROOT0;
				else if (k == MAX_ORDER - 2) heads_q[k] <= ROOT1;
				else if (k == MAX_ORDER - 3) heads_q[k] <= ROOT2;
				else if (k == MAX_ORDER - 4) heads_q[k] <= ROOT3;
				else                         heads_q[k] <= NIL;
			end
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == NIL - PW'(1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						res_status_q <= STATUS_OK;
						res_addr_q   <= '0;
						if (s_axis_tuser == OP_ALLOC) begin
							pages_q <= PGS_W'(s_axis_tdata[31:PAGE_SHIFT]) +
							           PGS_W'(|s_axis_tdata[PAGE_SHIFT-1:0]);
							want_q  <= '0;
							state_q <= S_SIZE;
						end else if (fpg >= FW'(NUM_PAGES)) begin
							res_status_q <= STATUS_BAD_FREE;
							state_q      <= S_DONE;
						end else begin
							pg_q    <= fpg[PW-1:0];
							state_q <= S_FRD;
						end
					end
				end
				S_SIZE: begin
					if (want_q > OMAX) begin
						res_status_q <= STATUS_NO_SPACE;
						state_q      <= S_DONE;
					end else if ((CW'(1) << want_q) < CW'(pages_q)) begin
						want_q <= want_q + ORDER_W'(1);
					end else begin
						o_q     <= want_q;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (o_q > OMAX) begin
						res_status_q <= STATUS_NO_SPACE;
						state_q      <= S_DONE;
					end else if (head_o == NIL) begin
						o_q <= o_q + ORDER_W'(1);
					end else begin
						pg_q    <= head_o;
						ul_pg_q <= head_o;
						ret_q   <= S_SPLIT;
						state_q <= S_UR;
					end
				end
				S_SPLIT: begin
					if (o_q > want_q) begin
						o_q <= o_dec;
						if (split_bud < NIL) begin
							push_pg_q  <= split_bud;
							push_tag_q <= {KIND_FREE, o_dec};
							ret_q      <= S_SPLIT;
							state_q    <= S_PA;
						end
					end else begin
						res_addr_q <= addr_x[ADDR_W-1:0];
						state_q    <= S_DONE;
					end
				end
				S_UR: state_q <= S_UW;
				S_UW: begin
					if (head_o == ul_pg_q) heads_q[o_q[HW-1:0]] <= nxt_rd;
					state_q <= ret_q;
				end
				S_PA: begin
					h_q                   <= head_o;
					heads_q[o_q[HW-1:0]]  <= push_pg_q;
					state_q               <= S_PB;
				end
				S_PB: state_q <= ret_q;
				S_FRD: state_q <= S_FTAG;
				S_FTAG: begin
					if (tag_rd[TAG_W-1:ORDER_W] != KIND_ALLOC ||
					    tag_rd[ORDER_W-1:0] > OMAX) begin
						res_status_q <= STATUS_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						o_q        <= tag_rd[ORDER_W-1:0];
						push_pg_q  <= pg_q;
						push_tag_q <= {KIND_FREE, tag_rd[ORDER_W-1:0]};
						ret_q      <= S_MCHK;
						state_q    <= S_PA;
					end
				end
				S_MCHK: begin
					bud_q <= bud_c;
					if (root_c || o_q >= OMAX || bud_c >= NIL) state_q <= S_DONE;
					else                                      state_q <= S_MTAG;
				end
				S_MTAG: begin
					if (tag_rd == {KIND_FREE, o_q}) begin
						ul_pg_q <= pg_q;
						ret_q   <= S_MUL2;
						state_q <= S_UR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL2: begin
					ul_pg_q <= bud_q;
					ret_q   <= S_MHI;
					state_q <= S_UR;
				end
				S_MHI: begin
					o_q        <= o_q + ORDER_W'(1);
					pg_q       <= lo_c;
					push_pg_q  <= lo_c;
					push_tag_q <= {KIND_FREE, o_q + ORDER_W'(1)};
					ret_q      <= S_MCHK;
					state_q    <= S_PA;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_addr_q, out_status_q};

endmodule

>>> rtl/bpa_checker.sv
// ---------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the buddy page allocator.
// ---------------------------------------------------------------------------
module bpa_checker
	import bpa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// one request in flight: busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != STATUS_OK |-> m_axis_tdata[23:2] == '0)
		else $error("failed request with nonzero address");

	// a waiting request stays on the bus unchanged
	a_req_held: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("waiting request changed");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
